FILE: rtl/tbv_pkg.sv
// ---------------------------------------------------------------------------
// tbv_pkg : shared types and constants
// Item and queue types, back-end state codes and the K=7 rate-1/3 code table
// used by the tail-biting Viterbi decoder.
// ---------------------------------------------------------------------------
package tbv_pkg;

   localparam int SOFT_PORT_W = 8;
   localparam int OUT_W       = 40;
   localparam int IDX_W       = 6;
   localparam int NSTATES     = 64;

   localparam logic [6:0] GEN_A = 7'o133;
   localparam logic [6:0] GEN_B = 7'o171;
   localparam logic [6:0] GEN_C = 7'o165;

   // one stored item, tagged with its place in the frame
   typedef struct packed {
      logic [SOFT_PORT_W-1:0] soft_a;
      logic [SOFT_PORT_W-1:0] soft_b;
      logic [SOFT_PORT_W-1:0] soft_c;
      logic [IDX_W-1:0]       idx;
      logic                   last;
   } item_type;

   // head of the queue between front and back
   typedef struct packed {
      logic     valid;
      item_type item;
   } queue_head_type;

   typedef enum logic [2:0] {
      ST_LOAD,
      ST_PRIME,
      ST_ACS,
      ST_SEARCH,
      ST_TB_PRIME,
      ST_TB,
      ST_DONE
   } back_state_type;

   // control strobes of the back-end sequencer
   typedef struct packed {
      logic take_item;
      logic init;
      logic acs_en;
      logic search_en;
      logic tb_start;
      logic tb_en;
      logic load_out;
   } back_ctl_type;

   // coded bits {a, b, c} of branch word f; register bit j meets tap 6-j
   function automatic logic [2:0] code_bits(input logic [6:0] f);
      logic [2:0] acc;
      acc = 3'b000;
      for (int j = 0; j < 7; j++) begin
         acc[2] = acc[2] ^ (GEN_A[6-j] & f[j]);
         acc[1] = acc[1] ^ (GEN_B[6-j] & f[j]);
         acc[0] = acc[0] ^ (GEN_C[6-j] & f[j]);
      end
      return acc;
   endfunction

endpackage

FILE: rtl/tbv_front.sv
// ---------------------------------------------------------------------------
// tbv_front : input side
// Accepts soft-value items, tags each with its frame position and an
// end-of-frame flag, and holds them in a four-entry queue for the back end.
// ---------------------------------------------------------------------------
module tbv_front import tbv_pkg::*; #(
   parameter int FRAME_LEN = 40
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_push,
   input  logic [SOFT_PORT_W-1:0] req_soft_a,
   input  logic [SOFT_PORT_W-1:0] req_soft_b,
   input  logic [SOFT_PORT_W-1:0] req_soft_c,
   output logic                   req_full,
   output queue_head_type         head,
   input  logic                   head_pop
);

   localparam int DEPTH = 4;
   localparam int PTR_W = 2;

   item_type           q_mem_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [PTR_W:0]     cnt_ff, cnt_in;
   logic [IDX_W-1:0]   idx_ff, idx_in;
   logic               push_ok;
   logic               pop_ok;
   logic               is_last;

   assign req_full = (cnt_ff == (PTR_W+1)'(DEPTH));
   assign push_ok  = req_push & ~req_full;
   assign pop_ok   = head_pop & (cnt_ff != '0);
   assign is_last  = (idx_ff == IDX_W'(FRAME_LEN - 1));

   // advance frame position and queue pointers
   always_comb begin
      idx_in    = idx_ff;
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push_ok) begin
         idx_in    = is_last ? '0 : idx_ff + 1'b1;
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (pop_ok) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      if (push_ok && !pop_ok) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (!push_ok && pop_ok) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff    <= '0;
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         idx_ff    <= idx_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // store the tagged item on transfer
   always_ff @(posedge clock) begin
      if (push_ok) begin
         q_mem_ff[wr_ptr_ff] <= '{soft_a: req_soft_a, soft_b: req_soft_b,
                                  soft_c: req_soft_c, idx: idx_ff, last: is_last};
      end
   end

   assign head.valid = (cnt_ff != '0);
   assign head.item  = q_mem_ff[rd_ptr_ff];

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= (PTR_W+1)'(DEPTH))
      else $error("queue count beyond depth");

   a_idx_bound: assert property (@(posedge clock) disable iff (reset)
      idx_ff <= IDX_W'(FRAME_LEN - 1))
      else $error("frame position beyond frame length");

   a_pop_valid: assert property (@(posedge clock) disable iff (reset)
      head_pop |-> head.valid)
      else $error("pop from an empty queue");

endmodule

FILE: rtl/tbv_back.sv
// ---------------------------------------------------------------------------
// tbv_back : decoder core
// Collects one frame of soft values, runs the wrap-around add-compare-select
// laps with 64 parallel units, finds the best final state and traces back.
// ---------------------------------------------------------------------------
module tbv_back import tbv_pkg::*; #(
   parameter int FRAME_LEN  = 40,
   parameter int LAPS       = 3,
   parameter int SOFT_WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  queue_head_type   head,
   output logic             head_pop,
   output logic             rsp_empty,
   input  logic             rsp_pop,
   output logic [OUT_W-1:0] rsp_decoded_bits
);

   localparam int NSTEPS = LAPS * FRAME_LEN;
   localparam int STEP_W = $clog2(NSTEPS);
   localparam int AW     = $clog2(FRAME_LEN);
   localparam int SW3    = 3 * SOFT_WIDTH;
   localparam int BM_W   = SOFT_WIDTH + 2;
   localparam int PM_W   = $clog2(NSTEPS * 3 * (2 ** (SOFT_WIDTH - 1)) + 1) + 1;
   localparam int MID_LO = (LAPS / 2) * FRAME_LEN;
   localparam int MID_HI = MID_LO + FRAME_LEN - 1;

   back_state_type           state_ff, state_in;
   back_ctl_type             ctl;

   logic [SW3-1:0]           soft_mem [FRAME_LEN];
   logic [SW3-1:0]           soft_q_ff;
   logic [AW-1:0]            k_ff;
   logic [STEP_W-1:0]        step_ff;
   logic signed [PM_W-1:0]   pm_ff [NSTATES];
   logic signed [PM_W-1:0]   pm_in [NSTATES];
   logic [NSTATES-1:0]       choice;
   logic [NSTATES-1:0]       surv_mem [NSTEPS];
   logic [NSTATES-1:0]       surv_q_ff;
   logic [STEP_W-1:0]        tb_ff;
   logic [STEP_W-1:0]        cur_ff;
   logic signed [PM_W-1:0]   best_ff;
   logic [5:0]               best_s_ff;
   logic [5:0]               srch_ff;
   logic [5:0]               s_ff;
   logic [FRAME_LEN-1:0]     word_ff;
   logic                     rsp_full_ff;
   logic [OUT_W-1:0]         rsp_data_ff;
   logic [OUT_W-1:0]         word_out;
   logic signed [SOFT_WIDTH-1:0] sa, sb, sc;
   logic signed [BM_W-1:0]   bm [8];
   logic                     last_step;
   logic                     in_mid;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_LOAD: begin
            if (head.valid && head.item.last) state_in = ST_PRIME;
         end
         ST_PRIME:    state_in = ST_ACS;
         ST_ACS: begin
            if (last_step) state_in = ST_SEARCH;
         end
         ST_SEARCH: begin
            if (srch_ff == 6'd63) state_in = ST_TB_PRIME;
         end
         ST_TB_PRIME: state_in = ST_TB;
         ST_TB: begin
            if (cur_ff == '0) state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_full_ff) state_in = ST_LOAD;
         end
         default:     state_in = ST_LOAD;
      endcase
   end

   // sequencer strobes
   always_comb begin
      ctl = '0;
      case (state_ff)
         ST_LOAD:     ctl.take_item = head.valid;
         ST_PRIME:    ctl.init      = 1'b1;
         ST_ACS:      ctl.acs_en    = 1'b1;
         ST_SEARCH:   ctl.search_en = 1'b1;
         ST_TB_PRIME: ctl.tb_start  = 1'b1;
         ST_TB:       ctl.tb_en     = 1'b1;
         ST_DONE:     ctl.load_out  = ~rsp_full_ff;
         default:     ctl = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

   assign head_pop  = ctl.take_item;
   assign last_step = (step_ff == STEP_W'(NSTEPS - 1));

   // soft store: write on load, read the next step's values every cycle
   always_ff @(posedge clock) begin
      if (ctl.take_item) begin
         soft_mem[head.item.idx[AW-1:0]] <= {SOFT_WIDTH'(head.item.soft_a),
                                            SOFT_WIDTH'(head.item.soft_b),
                                            SOFT_WIDTH'(head.item.soft_c)};
      end
      soft_q_ff <= soft_mem[k_ff];
   end

   // read address and step count
   always_ff @(posedge clock) begin
      if (reset) begin
         k_ff    <= '0;
         step_ff <= '0;
      end else if (ctl.take_item && head.item.last) begin
         k_ff    <= '0;
         step_ff <= '0;
      end else if (ctl.init || ctl.acs_en) begin
         k_ff    <= (k_ff == AW'(FRAME_LEN - 1)) ? '0 : k_ff + 1'b1;
         step_ff <= ctl.acs_en ? step_ff + 1'b1 : step_ff;
      end
   end

   // branch metrics for the eight code words
   assign sa = soft_q_ff[SW3-1 -: SOFT_WIDTH];
   assign sb = soft_q_ff[2*SOFT_WIDTH-1 -: SOFT_WIDTH];
   assign sc = soft_q_ff[SOFT_WIDTH-1:0];

   always_comb begin
      for (int c = 0; c < 8; c++) begin
         bm[c] = (c[2] ? -BM_W'(sa) : BM_W'(sa))
               + (c[1] ? -BM_W'(sb) : BM_W'(sb))
               + (c[0] ? -BM_W'(sc) : BM_W'(sc));
      end
   end

   // add-compare-select units, lower predecessor wins a tie
   for (genvar t = 0; t < NSTATES; t++) begin : g_acs
      localparam logic [2:0] CL = code_bits(7'(t));
      localparam logic [2:0] CH = code_bits(7'(t + 64));
      logic signed [PM_W-1:0] a_sum, b_sum;
      assign a_sum    = pm_ff[t / 2] + PM_W'(bm[CL]);
      assign b_sum    = pm_ff[t / 2 + 32] + PM_W'(bm[CH]);
      assign choice[t] = (a_sum < b_sum);
      assign pm_in[t]  = choice[t] ? b_sum : a_sum;
   end

   // metrics: clear, update, or shift down during the search
   always_ff @(posedge clock) begin
      for (int t = 0; t < NSTATES; t++) begin
         if (ctl.init) begin
            pm_ff[t] <= '0;
         end else if (ctl.acs_en) begin
            pm_ff[t] <= pm_in[t];
         end else if (ctl.search_en) begin
            pm_ff[t] <= (t < NSTATES - 1) ? pm_ff[(t + 1) % NSTATES] : pm_ff[t];
         end
      end
   end

   // survivor store: one word per step, registered read for traceback
   always_ff @(posedge clock) begin
      if (ctl.acs_en) begin
         surv_mem[step_ff] <= choice;
      end
      surv_q_ff <= surv_mem[tb_ff];
   end

   // search for the first largest final metric
   always_ff @(posedge clock) begin
      if (reset) begin
         srch_ff <= '0;
      end else if (ctl.search_en) begin
         srch_ff <= srch_ff + 1'b1;
      end else if (ctl.init) begin
         srch_ff <= '0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.search_en && (srch_ff == '0 || pm_ff[0] > best_ff)) begin
         best_ff   <= pm_ff[0];
         best_s_ff <= srch_ff;
      end
   end

   // traceback addresses
   always_ff @(posedge clock) begin
      if (reset) begin
         tb_ff  <= STEP_W'(NSTEPS - 1);
         cur_ff <= '0;
      end else if (ctl.init) begin
         tb_ff  <= STEP_W'(NSTEPS - 1);
      end else if (ctl.tb_start || ctl.tb_en) begin
         cur_ff <= tb_ff;
         tb_ff  <= (tb_ff == '0) ? '0 : tb_ff - 1'b1;
      end
   end

   assign in_mid = (cur_ff >= STEP_W'(MID_LO)) && (cur_ff <= STEP_W'(MID_HI));

   // walk the survivors back and collect the middle lap
   always_ff @(posedge clock) begin
      if (ctl.tb_start) begin
         s_ff <= best_s_ff;
      end else if (ctl.tb_en) begin
         s_ff <= {surv_q_ff[s_ff], s_ff[5:1]};
         if (in_mid) begin
            word_ff <= {s_ff[0], word_ff[FRAME_LEN-1:1]};
         end
      end
   end

   for (genvar j = 0; j < OUT_W; j++) begin : g_out
      if (j < FRAME_LEN) begin : g_bit
         assign word_out[j] = word_ff[j];
      end else begin : g_pad
         assign word_out[j] = 1'b0;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_full_ff <= 1'b0;
      end else if (ctl.load_out) begin
         rsp_full_ff <= 1'b1;
      end else if (rsp_pop) begin
         rsp_full_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load_out) begin
         rsp_data_ff <= word_out;
      end
   end

   assign rsp_empty        = ~rsp_full_ff;
   assign rsp_decoded_bits = rsp_data_ff;

   a_step_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_ACS |-> step_ff <= STEP_W'(NSTEPS - 1))
      else $error("ACS step beyond survivor depth");

   a_tb_exit: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_TB |=> state_ff == ST_TB || state_ff == ST_DONE)
      else $error("traceback left early");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      ctl.load_out |-> !rsp_full_ff)
      else $error("result overwritten before transfer");

endmodule

FILE: rtl/tail_biting_viterbi_k7_r13_core.sv
// ---------------------------------------------------------------------------
// tail_biting_viterbi_k7_r13_core : tail-biting Viterbi decoder, K=7, rate 1/3
// Decodes frames of soft-value triples with wrap-around laps and returns the
// middle lap's bits as one word.
// ---------------------------------------------------------------------------
//  channel   handshake          payload
//  request   req_push/req_full  req_soft_a, req_soft_b, req_soft_c
//  response  rsp_pop/rsp_empty  rsp_decoded_bits
//
//  Items enter one a cycle, while the queue is not full, into a four-entry
//  queue; the core drains it at one item a cycle while loading and the queue
//  holds items. A frame then passes through a priming state, the ACS steps of
//  all LAPS laps, a search over the 64 final metrics, a traceback priming
//  state and the traceback, with one ACS step and one survivor-memory read per
//  cycle. Reset is synchronous and clears all control state. A waiting result
//  stalls only the core; input still flows until the queue fills.
// ---------------------------------------------------------------------------
module tail_biting_viterbi_k7_r13_core import tbv_pkg::*; #(
   parameter int FRAME_LEN  = 40,
   parameter int LAPS       = 3,
   parameter int SOFT_WIDTH = 8
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_push,
   output logic                   req_full,
   input  logic [SOFT_PORT_W-1:0] req_soft_a,
   input  logic [SOFT_PORT_W-1:0] req_soft_b,
   input  logic [SOFT_PORT_W-1:0] req_soft_c,
   output logic                   rsp_empty,
   input  logic                   rsp_pop,
   output logic [OUT_W-1:0]       rsp_decoded_bits
);

   queue_head_type head;
   logic           head_pop;

   tbv_front #(
      .FRAME_LEN (FRAME_LEN)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_push   (req_push),
      .req_soft_a (req_soft_a),
      .req_soft_b (req_soft_b),
      .req_soft_c (req_soft_c),
      .req_full   (req_full),
      .head       (head),
      .head_pop   (head_pop)
   );

   tbv_back #(
      .FRAME_LEN  (FRAME_LEN),
      .LAPS       (LAPS),
      .SOFT_WIDTH (SOFT_WIDTH)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .head             (head),
      .head_pop         (head_pop),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_decoded_bits (rsp_decoded_bits)
   );

endmodule

FILE: verif/tb_tail_biting_viterbi_k7_r13_core.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_tail_biting_viterbi_k7_r13_core : decoder frame check
// Streams frames of soft triples into the decoder under random push and pop
// gaps, predicts each decoded word with an independent tail-biting Viterbi
// search and compares every word in order.
// ---------------------------------------------------------------------------
module tb_tail_biting_viterbi_k7_r13_core;
   import tbv_pkg::*;

   localparam int FRAME   = 40;
   localparam int NLAPS   = 3;
   localparam int NITEMS  = 1050;
   localparam int MAX_CYC = 2000000;

   // scoreboard: frame collector, decoder model and queue of expected words
   class frame_decoder;
      int          soft_mem[FRAME][3];
      int          fill;
      logic [39:0] words[$];
      int          errors;

      function int sext(logic [7:0] v);
         return int'($signed(v));
      endfunction

      function logic [2:0] enc(int f);
         logic [2:0] acc;
         logic [6:0] g[3];
         acc = 3'b000;
         g[0] = 7'o133; g[1] = 7'o171; g[2] = 7'o165;
         for (int j = 0; j < 7; j++)
            for (int n = 0; n < 3; n++)
               acc[2-n] ^= g[n][6-j] & f[j];
         return acc;
      endfunction

      function int bmet(int f, int k);
         logic [2:0] cb;
         int r;
         cb = enc(f);
         r = 0;
         for (int n = 0; n < 3; n++)
            r += cb[2-n] ? -soft_mem[k][n] : soft_mem[k][n];
         return r;
      endfunction

      function logic [39:0] run_frame();
         int          pm[64], npm[64];
         logic [63:0] surv[FRAME*NLAPS];
         logic        bits[FRAME*NLAPS];
         int          a, b, best, s, step;
         logic [39:0] w;
         step = 0;
         foreach (pm[t]) pm[t] = 0;
         for (int lap = 0; lap < NLAPS; lap++)
            for (int k = 0; k < FRAME; k++) begin
               surv[step] = '0;
               for (int t = 0; t < 64; t++) begin
                  a = pm[t>>1] + bmet(t, k);
                  b = pm[(t>>1)+32] + bmet(t+64, k);
                  if (a >= b) npm[t] = a;
                  else begin
                     npm[t] = b;
                     surv[step][t] = 1'b1;
                  end
               end
               pm = npm;
               step++;
            end
         best = 0;
         for (int t = 1; t < 64; t++) if (pm[t] > pm[best]) best = t;
         s = best;
         for (int i = FRAME*NLAPS-1; i >= 0; i--) begin
            bits[i] = s[0];
            s = (s >> 1) + (surv[i][s] ? 32 : 0);
         end
         w = '0;
         for (int k = 0; k < FRAME; k++) w = {w[38:0], bits[(NLAPS/2)*FRAME+k]};
         return w;
      endfunction

      // note an accepted input transfer
      function void note_item(logic [7:0] sa, logic [7:0] sb, logic [7:0] sc);
         soft_mem[fill][0] = sext(sa);
         soft_mem[fill][1] = sext(sb);
         soft_mem[fill][2] = sext(sc);
         fill++;
         if (fill == FRAME) begin
            fill = 0;
            words.push_back(run_frame());
         end
      endfunction

      // check an accepted result transfer
      function void check_word(logic [39:0] got);
         logic [39:0] exp_w;
         if (words.size() == 0) begin
            $error("decoded_bits: unexpected result %h", got);
            errors++;
            return;
         end
         exp_w = words.pop_front();
         if (got !== exp_w) begin
            $error("decoded_bits: expected %h actual %h", exp_w, got);
            errors++;
         end
      endfunction
   endclass

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_push = 1'b0;
   logic [7:0] req_soft_a = '0, req_soft_b = '0, req_soft_c = '0;
   logic       rsp_pop = 1'b0;
   wire        req_full, rsp_empty;
   wire [39:0] rsp_decoded_bits;

   frame_decoder sb = new();
   int  cycles = 0;
   bit  hold_rsp = 1'b0;
   int  sent = 0;

   tail_biting_viterbi_k7_r13_core dut (
      .clock, .reset, .req_push, .req_full, .req_soft_a, .req_soft_b,
      .req_soft_c, .rsp_empty, .rsp_pop, .rsp_decoded_bits
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // sample transfers at the rising edge
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (!reset && req_push && !req_full) sb.note_item(req_soft_a, req_soft_b, req_soft_c);
      if (!reset && rsp_pop && !rsp_empty) sb.check_word(rsp_decoded_bits);
      if (cycles > MAX_CYC) begin
         $display("FAIL tail_biting_viterbi_k7_r13_core");
         $finish;
      end
   end

   function int gap_len();
      return ($urandom_range(0, 19) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 2);
   endfunction

   // offer one item and hold it until transferred; push stays high for the next one
   task automatic push_item(logic [7:0] a, logic [7:0] b, logic [7:0] c, bit gaps);
      int g;
      g = gaps ? gap_len() : 0;
      if (g > 0) begin
         req_push <= 1'b0;
         repeat (g) @(negedge clock);
      end
      req_push <= 1'b1;
      req_soft_a <= a; req_soft_b <= b; req_soft_c <= c;
      @(posedge clock);
      while (req_full) @(posedge clock);
      @(negedge clock);
      sent++;
   endtask

   // encode a random message and add noise; mostly clean, some garbage
   task automatic push_frame(int mode, bit gaps);
      logic [5:0] st;
      logic [2:0] cb;
      logic [7:0] v[3];
      int amp;
      st = 6'($urandom());
      amp = $urandom_range(1, 127);
      for (int k = 0; k < FRAME; k++) begin
         st = {$urandom_range(0, 1) == 1, st[5:1]};
         cb = sb.enc({st, st[0]} ^ 7'd0);
         for (int n = 0; n < 3; n++) begin
            if (mode == 0) v[n] = 8'($urandom());
            else v[n] = cb[2-n] ? 8'(-(amp + $urandom_range(0, 127 - amp)))
                                : 8'(amp + $urandom_range(0, 127 - amp));
            if (mode == 1 && $urandom_range(0, 9) == 0) v[n] = 8'($urandom());
         end
         push_item(v[0], v[1], v[2], gaps);
      end
   endtask

   // result side: random pop gaps, long hold-off when asked
   initial begin
      int g;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (hold_rsp) begin
            rsp_pop <= 1'b0;
            repeat (1500) @(negedge clock);
            hold_rsp = 1'b0;
         end
         g = ($urandom_range(0, 3) == 0) ? gap_len() : 0;
         if (g > 0) begin
            rsp_pop <= 1'b0;
            repeat (g) @(negedge clock);
         end
         rsp_pop <= 1'b1;
         @(negedge clock);
      end
   end

   initial begin
      int frames;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      // directed: all-zero, extremes, ties
      for (int k = 0; k < FRAME; k++) push_item(8'h00, 8'h00, 8'h00, 0);
      for (int k = 0; k < FRAME; k++) push_item(8'h7f, 8'h80, 8'h7f, 0);
      for (int k = 0; k < FRAME; k++)
         push_item(k[0] ? 8'h80 : 8'h7f, 8'hff, k[1] ? 8'h01 : 8'h80, 0);
      req_push <= 1'b0;
      // pause until the decoder has drained
      while (sb.words.size() != 0) @(negedge clock);
      // receiver holds off while frames keep arriving
      hold_rsp = 1'b1;
      push_frame(1, 0);
      push_frame(0, 0);
      push_frame(1, 0);
      frames = (NITEMS - sent) / FRAME + 1;
      for (int f = 0; f < frames; f++) push_frame(($urandom_range(0, 4) == 0) ? 0 : 1, f % 4 != 3);
      req_push <= 1'b0;
      while (sb.words.size() != 0) @(negedge clock);
      repeat (400) @(negedge clock);
      if (sb.errors == 0 && sb.words.size() == 0)
         $display("PASS tail_biting_viterbi_k7_r13_core");
      else
         $display("FAIL tail_biting_viterbi_k7_r13_core");
      $finish;
   end
endmodule
